[rtl/core/cma_nlms_multipath_equalizer_assert.svh]
// Assertion macros for the equalizer RTL.
// Depends on nothing; included by the top level module to check its own logic.
`ifndef CMA_NLMS_MULTIPATH_EQUALIZER_ASSERT_SVH
`define CMA_NLMS_MULTIPATH_EQUALIZER_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define CMAE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define CMAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cmae_pkg.sv]
// Types and constants of the constant-modulus NLMS equalizer.
// Used by the divider unit and the top level; depends on nothing.
package cmae_pkg;

   // Fixed widths of the datapath.
   localparam int SAMPLE_W = 16;
   localparam int OUT_W    = 18;
   localparam int COEF_W   = 24;
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = 25;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int ACC_W    = 48;
   localparam int POWER_W  = 38;
   localparam int DEN_W    = POWER_W + 1;
   localparam int ENV_W    = 38;
   localparam int ERR_W    = 22;
   localparam int NUM_W    = 54;
   localparam int F_W      = 32;
   localparam int T_W      = 49;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_STEP_GAIN    = 2'd0;
   localparam logic [1:0] CSR_TARGET_LEVEL = 2'd1;
   localparam logic [1:0] CSR_DIV_LIMIT    = 2'd2;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PWR,
      ST_FIR,
      ST_FIR_END,
      ST_ROUND,
      ST_ENV0,
      ST_ENV1,
      ST_ENV2,
      ST_ERR,
      ST_NUM,
      ST_NUM2,
      ST_DIV,
      ST_U0,
      ST_U1,
      ST_U2,
      ST_UPD,
      ST_DONE
   } cmae_state_type;

   // What to do with the product when it leaves the multiplier register.
   typedef enum logic [3:0] {
      P_NONE,
      P_PWR_ADD,
      P_PWR_SUB,
      P_ACC_I_ADD,
      P_ACC_I_SUB,
      P_ACC_Q_ADD,
      P_ENV_LOAD,
      P_ENV_ADD,
      P_UI,
      P_UQ,
      P_T_LOAD_I,
      P_T_ADD_I,
      P_T_LOAD_Q
   } cmae_prod_op_type;

   // Divider request and response.
   typedef struct packed {
      logic             start;
      logic             neg;
      logic [NUM_W-1:0] mag;
   } cmae_div_req_type;

   typedef struct packed {
      logic                  done;
      logic signed [F_W-1:0] quo;
   } cmae_div_rsp_type;

endpackage

[rtl/core/cma_nlms_multipath_equalizer.sv]
// Channel   | Ports                                    | Beat
// req       | req_tvalid/tready, req_tdata, req_tuser  | one complex sample
// rsp       | rsp_tvalid/tready, rsp_tdata             | one filter output and status
// csr       | csr_we, csr_addr, csr_wdata              | one register write
// Each accepted sample runs the filter pass, and a coefficient pass when it adapts
// (NTAPS = 4*TAP_STAGES+1 taps). The single shared multiplier paces both: four
// products per tap for the filter pass and for the coefficient pass, and the step
// normalization runs at one quotient bit per cycle. The block takes one sample at a
// time. Reset is synchronous and clears the control state at once; datapath registers
// have no reset (valid bits stand in for the delay line and coefficient contents).
// A stalled result holds the sequencer in its last state; the next sample is taken
// once the result is queued.
module cma_nlms_multipath_equalizer
   import cmae_pkg::*;
#(
   parameter int TAP_STAGES = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_i [15:0], sample_q [31:16]
   input  logic        req_tuser,   // block_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // out_i, out_q, error_value, updated, diverged
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [16:0] csr_wdata
);

   localparam int NTAPS   = 4 * TAP_STAGES + 1;
   localparam int REF_TAP = 3 * TAP_STAGES + 1;
   localparam int IDX_W   = $clog2(NTAPS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NTAPS - 1);
   localparam logic [IDX_W-1:0] REF_IDX  = IDX_W'(REF_TAP);
   localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sh400000;
   localparam logic [2*COEF_W-1:0] REF_VALUE = {{COEF_W{1'b0}}, COEF_ONE};

   // Sequencer and configuration.
   cmae_state_type      state_ff, state_in;
   logic [2:0]          sub_ff, sub_in;
   logic [IDX_W-1:0]    tap_ff, idx_ff, wp_ff;
   logic [IDX_W-1:0]    tap_nxt, idx_nxt, wp_nxt;
   logic                last_tap;
   logic [1:0]          phase_ff;
   logic                diverged_ff;
   logic [15:0]         step_gain_ff, target_ff;
   logic [16:0]         limit_ff;

   // Datapath registers.
   logic signed [SAMPLE_W-1:0] x_i_ff, x_q_ff;
   logic                       start_ff;
   logic [POWER_W-1:0]         power_ff;
   logic signed [ACC_W-1:0]    acc_i_ff, acc_q_ff;
   logic signed [ENV_W-1:0]    env_ff;
   logic signed [OUT_W-1:0]    y_i_ff, y_q_ff, last_err_ff;
   logic signed [ERR_W-1:0]    last_err_raw_ff;
   logic                       upd_ff;
   logic signed [F_W-1:0]      f_ff, ui_ff, uq_ff;
   logic signed [T_W-1:0]      ti_ff, tq_ff;
   logic                       rsp_vld_ff;
   logic [55:0]                rsp_data_ff;

   // Shared multiplier.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   cmae_prod_op_type          mul_op, prod_op_ff;
   logic signed [PROD_W-1:0]  prod_ff;

   // Memories and their read ports.
   logic [2*SAMPLE_W-1:0] line_mem [NTAPS];
   logic [2*COEF_W-1:0]   coef_mem [NTAPS];
   logic [NTAPS-1:0]      line_vld_ff, coef_vld_ff;
   logic                  line_rd_en, coef_rd_en, line_we, coef_we;
   logic [IDX_W-1:0]      line_rd_addr, coef_rd_addr;
   logic [2*SAMPLE_W-1:0] line_rd_ff;
   logic [2*COEF_W-1:0]   coef_rd_ff, coef_wdata;
   logic                  line_rdv_ff, coef_rdv_ff, coef_ref_ff;
   logic signed [SAMPLE_W-1:0] li, lq;
   logic signed [COEF_W-1:0]   ci, cq;

   // Divider.
   cmae_div_req_type div_req;
   cmae_div_rsp_type div_rsp;

   logic accept, slot_free, upd_now;
   logic [1:0] phase_now;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign slot_free  = !rsp_vld_ff || rsp_tready;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign last_tap  = (tap_ff == LAST_IDX);
   assign tap_nxt   = last_tap ? '0 : tap_ff + 1'b1;
   assign idx_nxt   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign wp_nxt    = (wp_ff == LAST_IDX) ? '0 : wp_ff + 1'b1;
   assign phase_now = start_ff ? 2'd0 : phase_ff;
   assign upd_now   = (phase_now == 2'd0);

   // Read data with reset values for entries never written.
   always_comb begin
      li = line_rdv_ff ? $signed(line_rd_ff[SAMPLE_W-1:0]) : '0;
      lq = line_rdv_ff ? $signed(line_rd_ff[2*SAMPLE_W-1:SAMPLE_W]) : '0;
      if (coef_rdv_ff) begin
         ci = $signed(coef_rd_ff[COEF_W-1:0]);
         cq = $signed(coef_rd_ff[2*COEF_W-1:COEF_W]);
      end else begin
         ci = coef_ref_ff ? COEF_ONE : '0;
         cq = '0;
      end
   end

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
      end
   end

   // Next state, step counter and memory controls.
   always_comb begin
      state_in     = state_ff;
      sub_in       = '0;
      line_rd_en   = 1'b0;
      line_rd_addr = idx_nxt;
      coef_rd_en   = 1'b0;
      coef_rd_addr = tap_nxt;
      line_we      = 1'b0;
      coef_we      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            line_rd_addr = wp_ff;
            if (accept) begin
               line_rd_en = 1'b1;
               state_in   = ST_PWR;
            end
         end
         ST_PWR: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == 3'd3) begin
               sub_in       = '0;
               line_we      = 1'b1;
               line_rd_en   = 1'b1;
               line_rd_addr = wp_nxt;
               coef_rd_en   = 1'b1;
               coef_rd_addr = '0;
               state_in     = ST_FIR;
            end
         end
         ST_FIR: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == 3'd3) begin
               sub_in     = '0;
               line_rd_en = 1'b1;
               coef_rd_en = 1'b1;
               if (last_tap) begin
                  state_in = ST_FIR_END;
               end
            end
         end
         ST_FIR_END: state_in = ST_ROUND;
         ST_ROUND:   state_in = upd_now ? ST_ENV0 : ST_DONE;
         ST_ENV0:    state_in = ST_ENV1;
         ST_ENV1:    state_in = ST_ENV2;
         ST_ENV2:    state_in = ST_ERR;
         ST_ERR:     state_in = ST_NUM;
         ST_NUM:     state_in = ST_NUM2;
         ST_NUM2:    state_in = ST_DIV;
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_U0;
            end
         end
         ST_U0: state_in = ST_U1;
         ST_U1: state_in = ST_U2;
         ST_U2: begin
            line_rd_en   = 1'b1;
            line_rd_addr = wp_ff;
            coef_rd_en   = 1'b1;
            coef_rd_addr = '0;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            sub_in = sub_ff + 1'b1;
            if (sub_ff == 3'd4) begin
               sub_in     = '0;
               coef_we    = 1'b1;
               line_rd_en = 1'b1;
               coef_rd_en = 1'b1;
               if (last_tap) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_op = P_NONE;
      case (state_ff)
         ST_PWR: begin
            case (sub_ff)
               3'd0: begin
                  mul_a = MUL_A_W'(x_i_ff); mul_b = MUL_B_W'(x_i_ff); mul_op = P_PWR_ADD;
               end
               3'd1: begin
                  mul_a = MUL_A_W'(x_q_ff); mul_b = MUL_B_W'(x_q_ff); mul_op = P_PWR_ADD;
               end
               3'd2: begin
                  mul_a = MUL_A_W'(li); mul_b = MUL_B_W'(li); mul_op = P_PWR_SUB;
               end
               default: begin
                  mul_a = MUL_A_W'(lq); mul_b = MUL_B_W'(lq); mul_op = P_PWR_SUB;
               end
            endcase
         end
         ST_FIR: begin
            case (sub_ff)
               3'd0: begin
                  mul_a = MUL_A_W'(ci); mul_b = MUL_B_W'(li); mul_op = P_ACC_I_ADD;
               end
               3'd1: begin
                  mul_a = MUL_A_W'(cq); mul_b = MUL_B_W'(lq); mul_op = P_ACC_I_SUB;
               end
               3'd2: begin
                  mul_a = MUL_A_W'(cq); mul_b = MUL_B_W'(li); mul_op = P_ACC_Q_ADD;
               end
               default: begin
                  mul_a = MUL_A_W'(ci); mul_b = MUL_B_W'(lq); mul_op = P_ACC_Q_ADD;
               end
            endcase
         end
         ST_ENV0: begin
            mul_a = MUL_A_W'(y_i_ff); mul_b = MUL_B_W'(y_i_ff); mul_op = P_ENV_LOAD;
         end
         ST_ENV1: begin
            mul_a = MUL_A_W'(y_q_ff); mul_b = MUL_B_W'(y_q_ff); mul_op = P_ENV_ADD;
         end
         ST_NUM: begin
            mul_a = MUL_A_W'(last_err_raw_ff);
            mul_b = MUL_B_W'($signed({1'b0, step_gain_ff}));
         end
         ST_U0: begin
            mul_a = MUL_A_W'(f_ff); mul_b = MUL_B_W'(y_i_ff); mul_op = P_UI;
         end
         ST_U1: begin
            mul_a = MUL_A_W'(f_ff); mul_b = MUL_B_W'(y_q_ff); mul_op = P_UQ;
         end
         ST_UPD: begin
            case (sub_ff)
               3'd0: begin
                  mul_a = MUL_A_W'(ui_ff); mul_b = MUL_B_W'(li); mul_op = P_T_LOAD_I;
               end
               3'd1: begin
                  mul_a = MUL_A_W'(uq_ff); mul_b = MUL_B_W'(lq); mul_op = P_T_ADD_I;
               end
               3'd2: begin
                  mul_a = MUL_A_W'(uq_ff); mul_b = MUL_B_W'(li); mul_op = P_T_LOAD_Q;
               end
               default: begin
                  mul_a = MUL_A_W'(ui_ff); mul_b = MUL_B_W'(lq);
               end
            endcase
         end
         default: begin
            mul_op = P_NONE;
         end
      endcase
   end

   // The multiplier and its output register.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_op_ff <= P_NONE;
      end else begin
         prod_op_ff <= mul_op;
      end
   end

   // Output rounding and divergence test on the accumulated dot product.
   logic signed [ACC_W-1:0] acc_rnd_i, acc_rnd_q;
   logic signed [25:0]      yw_i, yw_q;
   logic signed [26:0]      lim_s;
   logic                    y_beyond;
   logic signed [OUT_W-1:0] ys_i, ys_q;

   always_comb begin
      acc_rnd_i = acc_i_ff + 48'sd2097152;
      acc_rnd_q = acc_q_ff + 48'sd2097152;
      yw_i      = $signed(acc_rnd_i[ACC_W-1:22]);
      yw_q      = $signed(acc_rnd_q[ACC_W-1:22]);
      lim_s     = $signed({10'd0, limit_ff});
      y_beyond  = (yw_i > lim_s) || (yw_i < -lim_s) || (yw_q > lim_s) || (yw_q < -lim_s);
      ys_i = (yw_i > 26'sd131071) ? 18'sh1FFFF :
             (yw_i < -26'sd131072) ? 18'sh20000 : yw_i[OUT_W-1:0];
      ys_q = (yw_q > 26'sd131071) ? 18'sh1FFFF :
             (yw_q < -26'sd131072) ? 18'sh20000 : yw_q[OUT_W-1:0];
   end

   // Constant-modulus error from the squared envelope.
   logic signed [ENV_W-1:0] env_rnd;
   logic signed [ERR_W-1:0] e_now;
   logic signed [ERR_W:0]   e_dbl;
   logic signed [ERR_W:0]   lim_e;
   logic signed [OUT_W-1:0] e_sat;

   always_comb begin
      env_rnd = env_ff + 38'sd32768;
      e_now   = $signed({6'd0, target_ff}) - $signed(env_rnd[ERR_W+15:16]);
      e_dbl   = {e_now, 1'b0};
      lim_e   = $signed({6'd0, limit_ff});
      e_sat   = (e_now > 22'sd131071) ? 18'sh1FFFF :
                (e_now < -22'sd131072) ? 18'sh20000 : e_now[OUT_W-1:0];
   end

   // Step factors u = f*y rounded to Q.22 and saturated.
   logic signed [PROD_W-1:0] u_rnd, u_w;
   logic signed [F_W-1:0]    u_sat;

   always_comb begin
      u_rnd = prod_ff + 58'sd256;
      u_w   = u_rnd >>> 9;
      u_sat = (u_w > 58'sd2147483647) ? 32'sh7FFFFFFF :
              (u_w < -58'sd2147483648) ? 32'sh80000000 : u_w[F_W-1:0];
   end

   // Coefficient write-back for the current tap.
   logic signed [T_W-1:0] tq_full, ti_rnd, tq_rnd;
   logic signed [T_W:0]   ci_sum, cq_sum;
   logic signed [COEF_W-1:0] ci_new, cq_new;

   always_comb begin
      tq_full = tq_ff - $signed(prod_ff[T_W-1:0]);
      ti_rnd  = (ti_ff + 49'sd16384) >>> 15;
      tq_rnd  = (tq_full + 49'sd16384) >>> 15;
      ci_sum  = (T_W+1)'(ti_rnd) + (T_W+1)'(ci);
      cq_sum  = (T_W+1)'(tq_rnd) + (T_W+1)'(cq);
      ci_new  = (ci_sum > 50'sd8388607) ? 24'sh7FFFFF :
                (ci_sum < -50'sd8388608) ? 24'sh800000 : ci_sum[COEF_W-1:0];
      cq_new  = (cq_sum > 50'sd8388607) ? 24'sh7FFFFF :
                (cq_sum < -50'sd8388608) ? 24'sh800000 : cq_sum[COEF_W-1:0];
      coef_wdata = (tap_ff == REF_IDX) ? REF_VALUE : {cq_new, ci_new};
   end

   // Divider request: magnitude of e*gain*65536 and its sign.
   logic signed [PROD_W-1:0] prod_abs;

   always_comb begin
      prod_abs      = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
      div_req.start = (state_ff == ST_NUM2);
      div_req.neg   = prod_ff[PROD_W-1];
      div_req.mag   = {prod_abs[NUM_W-17:0], 16'd0};
   end

   cmae_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .den     (DEN_W'(power_ff) + 1'b1),
      .div_rsp (div_rsp)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_gain_ff <= 16'd655;
         target_ff    <= 16'd16384;
         limit_ff     <= 17'd65535;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_STEP_GAIN:    step_gain_ff <= csr_wdata[15:0];
            CSR_TARGET_LEVEL: target_ff    <= csr_wdata[15:0];
            CSR_DIV_LIMIT:    limit_ff     <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Control state: positions, phase, flags, valid bits and the result beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         phase_ff    <= '0;
         diverged_ff <= 1'b0;
         last_err_ff <= '0;
         line_vld_ff <= '0;
         coef_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
         power_ff    <= '0;
      end else begin
         // A new result beat replaces the one leaving in the same cycle.
         if (state_ff == ST_DONE && slot_free) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
         if (line_we) begin
            wp_ff              <= wp_nxt;
            line_vld_ff[wp_ff] <= 1'b1;
         end
         if (coef_we) begin
            coef_vld_ff[tap_ff] <= 1'b1;
         end
         if (state_ff == ST_ROUND) begin
            phase_ff <= phase_now + 1'b1;
            if (y_beyond) begin
               diverged_ff <= 1'b1;
            end
         end
         if (state_ff == ST_ERR) begin
            last_err_ff <= e_sat;
            if ((e_dbl > lim_e) || (e_dbl < -lim_e)) begin
               diverged_ff <= 1'b1;
            end
         end
         if (prod_op_ff == P_PWR_ADD) begin
            power_ff <= power_ff + prod_ff[POWER_W-1:0];
         end else if (prod_op_ff == P_PWR_SUB) begin
            power_ff <= power_ff - prod_ff[POWER_W-1:0];
         end
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         x_i_ff   <= $signed(req_tdata[15:0]);
         x_q_ff   <= $signed(req_tdata[31:16]);
         start_ff <= req_tuser;
         acc_i_ff <= '0;
         acc_q_ff <= '0;
      end
      if (line_rd_en) begin
         tap_ff <= (state_ff == ST_PWR || state_ff == ST_U2) ? '0 : tap_nxt;
         idx_ff <= line_rd_addr;
      end
      if (state_ff == ST_ROUND) begin
         y_i_ff <= ys_i;
         y_q_ff <= ys_q;
         upd_ff <= upd_now;
      end
      if (state_ff == ST_ERR) begin
         last_err_raw_ff <= e_now;
      end
      if (div_rsp.done) begin
         f_ff <= div_rsp.quo;
      end
      if (state_ff == ST_DONE && slot_free) begin
         rsp_data_ff <= {diverged_ff, upd_ff, last_err_ff, y_q_ff, y_i_ff};
      end
      case (prod_op_ff)
         P_ACC_I_ADD: acc_i_ff <= acc_i_ff + $signed(prod_ff[ACC_W-1:0]);
         P_ACC_I_SUB: acc_i_ff <= acc_i_ff - $signed(prod_ff[ACC_W-1:0]);
         P_ACC_Q_ADD: acc_q_ff <= acc_q_ff + $signed(prod_ff[ACC_W-1:0]);
         P_ENV_LOAD:  env_ff   <= $signed(prod_ff[ENV_W-1:0]);
         P_ENV_ADD:   env_ff   <= env_ff + $signed(prod_ff[ENV_W-1:0]);
         P_UI:        ui_ff    <= u_sat;
         P_UQ:        uq_ff    <= u_sat;
         P_T_LOAD_I:  ti_ff    <= $signed(prod_ff[T_W-1:0]);
         P_T_ADD_I:   ti_ff    <= ti_ff + $signed(prod_ff[T_W-1:0]);
         P_T_LOAD_Q:  tq_ff    <= $signed(prod_ff[T_W-1:0]);
         default:     ;
      endcase
   end

   // Delay line memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[wp_ff] <= {x_q_ff, x_i_ff};
      end
      if (line_rd_en) begin
         line_rd_ff  <= line_mem[line_rd_addr];
         line_rdv_ff <= line_vld_ff[line_rd_addr];
      end
   end

   // Coefficient memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[tap_ff] <= coef_wdata;
      end
      if (coef_rd_en) begin
         coef_rd_ff  <= coef_mem[coef_rd_addr];
         coef_rdv_ff <= coef_vld_ff[coef_rd_addr];
         coef_ref_ff <= (coef_rd_addr == REF_IDX);
      end
   end

   // Checks on the sequencer and the coefficient pass.
`include "cma_nlms_multipath_equalizer_assert.svh"

   `CMAE_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready, "sample taken while busy")
   `CMAE_ASSERT_SAME(a_div_done_in_div, clock, reset, div_rsp.done, state_ff == ST_DIV, "stray quotient")
   `CMAE_ASSERT_SAME(a_ref_pinned, clock, reset, coef_we && (tap_ff == REF_IDX), coef_wdata == REF_VALUE, "reference tap not pinned")
   `CMAE_ASSERT_SAME(a_line_write_in_pwr, clock, reset, line_we, state_ff == ST_PWR && sub_ff == 3'd3, "delay line written outside the power step")

endmodule

[rtl/core/cmae_div.sv]
// Restoring divider for the normalized step, one quotient bit per cycle.
// Depends on cmae_pkg; the quotient is truncated toward zero and saturated to 32 bits.
module cmae_div
   import cmae_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmae_div_req_type div_req,
   input  logic [DEN_W-1:0] den,
   output cmae_div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [NUM_W-1:0] POS_LIM = {{(NUM_W-F_W){1'b0}}, 1'b0, {(F_W-1){1'b1}}};
   localparam logic [NUM_W-1:0] NEG_LIM = {{(NUM_W-F_W){1'b0}}, 1'b1, {(F_W-1){1'b0}}};

   logic             busy_ff;
   logic             done_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W:0]   rem_sh;
   logic             fits;
   logic [DEN_W:0]   rem_diff;
   logic [DEN_W-1:0] rem_in;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   always_comb begin
      rem_sh   = {rem_ff, num_ff[NUM_W-1]};
      fits     = rem_sh >= {1'b0, den};
      rem_diff = rem_sh - {1'b0, den};
      rem_in   = fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
   end

   // Control of the iteration.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Dividend, remainder and quotient bits; the quotient fills num_ff.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         num_ff <= div_req.mag;
         rem_ff <= '0;
         neg_ff <= div_req.neg;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   // Apply the sign and saturate.
   always_comb begin
      div_rsp.done = done_ff;
      if (!neg_ff) begin
         div_rsp.quo = (num_ff > POS_LIM) ? $signed(POS_LIM[F_W-1:0])
                                           : $signed(num_ff[F_W-1:0]);
      end else begin
         div_rsp.quo = (num_ff > NEG_LIM) ? $signed(NEG_LIM[F_W-1:0])
                                           : -$signed(num_ff[F_W-1:0]);
      end
   end

endmodule
